[rtl/core/sawarq_pkg.sv]
package sawarq_pkg;

    // sizes
    localparam int NUM_DESTS = 2;
    localparam int DEST_AW   = (NUM_DESTS > 1) ? $clog2(NUM_DESTS) : 1;
    localparam int SEQ_W     = 32;
    localparam int TICKS_W   = 16;
    localparam int TRIES_W   = 4;
    localparam int MODE_W    = 2;
    localparam int EV_W      = 3;
    localparam int CFG_AW    = 1;
    localparam int CFG_DW    = TICKS_W;

    // request kinds
    localparam logic [MODE_W-1:0] MODE_TICK = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SEND = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ACK  = 2'd2;

    // result events
    localparam logic [EV_W-1:0] EV_NONE    = 3'd0;
    localparam logic [EV_W-1:0] EV_SENT    = 3'd1;
    localparam logic [EV_W-1:0] EV_RETX    = 3'd2;
    localparam logic [EV_W-1:0] EV_DROP    = 3'd3;
    localparam logic [EV_W-1:0] EV_ACKED   = 3'd4;
    localparam logic [EV_W-1:0] EV_REFUSED = 3'd5;
    localparam logic [EV_W-1:0] EV_IGNORED = 3'd6;

    // register indexes
    localparam logic [CFG_AW-1:0] CFG_TIMEOUT = 1'd0;
    localparam logic [CFG_AW-1:0] CFG_TRIES   = 1'd1;

    // register reset values
    localparam logic [TICKS_W-1:0] TIMEOUT_RST = 16'd175;
    localparam logic [TRIES_W-1:0] TRIES_RST   = 4'd4;

    typedef logic [SEQ_W-1:0]   seq_t;
    typedef logic [DEST_AW-1:0] dest_addr_t;

endpackage

[rtl/core/sawarq_ram.sv]
module sawarq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single write port, registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/stop_and_wait_arq_sender.sv]
// channel   dir  handshake          tuser              tdata
// s_        in   s_tvalid/s_tready  [1:0] mode         [0] dest_index, [32:1] ack_seq
// m_        out  m_tvalid/m_tready  [2:0] event_res    [31:0] seq_out, [32] dest_out,
//                                                       [36:33] attempt
// cfg       in   cfg_wr_en          -                  cfg_addr index, cfg_wr_data value
//
// one request per cycle sustained unless m_tready stalls the output; each request is registered
// with its counter memory read in the execute stage, then executed into the output register
// aresetn is synchronous; per-destination valid bits make the counters read as zero at once,
// so there is no clearing pass after reset
// a stalled result holds in the output register; the execute stage moves into it in the
// same cycle it is freed, so input is only held off while both stages are full
module stop_and_wait_arq_sender
    import sawarq_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [39:0]        s_tdata,     // [0] dest_index, [32:1] ack_seq
    input  logic [MODE_W-1:0]  s_tuser,     // [1:0] mode
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [39:0]        m_tdata,     // [31:0] seq_out, [32] dest_out, [36:33] attempt
    output logic [EV_W-1:0]    m_tuser,     // [2:0] event_res
    input  logic               cfg_wr_en,
    input  logic [CFG_AW-1:0]  cfg_addr,
    input  logic [CFG_DW-1:0]  cfg_wr_data
);

    // configuration
    logic [TICKS_W-1:0] timeout_ticks_reg;
    logic [TRIES_W-1:0] max_tries_reg;

    // execute stage
    logic               p_vld_reg;
    logic [MODE_W-1:0]  p_mode_reg;
    dest_addr_t         p_addr_reg;
    seq_t               p_ack_reg;

    // held packet state
    logic               busy_reg, busy_next;
    seq_t               hseq_reg, hseq_next;
    logic               hdest_reg, hdest_next;
    logic [TRIES_W-1:0] tc_reg, tc_next, tc_inc;
    logic [TICKS_W-1:0] cd_reg, cd_next;

    // counter memory side
    logic [NUM_DESTS-1:0] seq_vld_reg;
    logic               fwd_vld_reg;
    dest_addr_t         fwd_addr_reg;
    seq_t               fwd_data_reg;
    seq_t               ram_rdata;
    seq_t               seq_cur;
    logic               ram_we;
    seq_t               ram_wdata;
    dest_addr_t         in_addr;
    logic               in_fire;
    logic               exec_fire;
    logic               advance;

    // output register
    logic               o_vld_reg;
    logic [EV_W-1:0]    o_ev_reg, ev_next;
    seq_t               o_seq_reg, seq_next;
    logic               o_dest_reg, dest_next;
    logic [TRIES_W-1:0] o_att_reg, att_next;

    // flow control
    assign advance   = !o_vld_reg || m_tready;
    assign exec_fire = p_vld_reg && advance;
    assign s_tready  = !p_vld_reg || advance;
    assign in_fire   = s_tvalid && s_tready;

    // destination index saturated to the table
    always_comb begin
        if ({4'b0, s_tdata[0]} >= 5'(NUM_DESTS)) begin
            in_addr = DEST_AW'(NUM_DESTS - 1);
        end else begin
            in_addr = DEST_AW'(s_tdata[0]);
        end
    end

    // per-destination sequence counters
    sawarq_ram #(
        .WIDTH (SEQ_W),
        .DEPTH (NUM_DESTS)
    ) u_seq_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (p_addr_reg),
        .wdata (ram_wdata),
        .re    (in_fire),
        .raddr (in_addr),
        .rdata (ram_rdata)
    );

    // current counter value: forwarded write, memory, or reset zero
    always_comb begin
        if (fwd_vld_reg && (fwd_addr_reg == p_addr_reg)) begin
            seq_cur = fwd_data_reg;
        end else if (seq_vld_reg[p_addr_reg]) begin
            seq_cur = ram_rdata;
        end else begin
            seq_cur = '0;
        end
    end

    assign tc_inc    = tc_reg + 4'd1;
    assign ram_wdata = seq_cur + 32'd1;

    // event execution
    always_comb begin
        busy_next  = busy_reg;
        hseq_next  = hseq_reg;
        hdest_next = hdest_reg;
        tc_next    = tc_reg;
        cd_next    = cd_reg;
        ev_next    = EV_NONE;
        seq_next   = '0;
        dest_next  = 1'b0;
        att_next   = '0;
        ram_we     = 1'b0;
        case (p_mode_reg)
            MODE_TICK: begin
                if (busy_reg) begin
                    if (cd_reg > 16'd1) begin
                        cd_next = cd_reg - 16'd1;
                    end else begin
                        seq_next  = hseq_reg;
                        dest_next = hdest_reg;
                        att_next  = tc_inc;
                        if (tc_inc >= max_tries_reg) begin
                            ev_next   = EV_DROP;
                            busy_next = 1'b0;
                            tc_next   = '0;
                            cd_next   = '0;
                        end else begin
                            ev_next = EV_RETX;
                            tc_next = tc_inc;
                            cd_next = timeout_ticks_reg;
                        end
                    end
                end
            end
            MODE_SEND: begin
                if (busy_reg) begin
                    ev_next   = EV_REFUSED;
                    seq_next  = hseq_reg;
                    dest_next = hdest_reg;
                    att_next  = tc_reg;
                end else begin
                    ev_next    = EV_SENT;
                    seq_next   = seq_cur;
                    dest_next  = p_addr_reg[0];
                    hseq_next  = seq_cur;
                    hdest_next = p_addr_reg[0];
                    tc_next    = '0;
                    cd_next    = timeout_ticks_reg;
                    busy_next  = 1'b1;
                    ram_we     = exec_fire;
                end
            end
            MODE_ACK: begin
                if (busy_reg && (p_ack_reg == hseq_reg)) begin
                    ev_next   = EV_ACKED;
                    seq_next  = hseq_reg;
                    dest_next = hdest_reg;
                    att_next  = tc_reg;
                    busy_next = 1'b0;
                    tc_next   = '0;
                    cd_next   = '0;
                end else begin
                    ev_next  = EV_IGNORED;
                    seq_next = p_ack_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_ticks_reg <= TIMEOUT_RST;
            max_tries_reg     <= TRIES_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_TIMEOUT: timeout_ticks_reg <= cfg_wr_data;
                CFG_TRIES:   max_tries_reg     <= cfg_wr_data[TRIES_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // execute stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_vld_reg <= 1'b0;
        end else if (s_tready) begin
            p_vld_reg <= s_tvalid;
        end
    end

    // execute stage payload
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            p_mode_reg <= s_tuser;
            p_addr_reg <= in_addr;
            p_ack_reg  <= s_tdata[32:1];
        end
    end

    // held packet state and counter bookkeeping
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            hseq_reg     <= '0;
            hdest_reg    <= 1'b0;
            tc_reg       <= '0;
            cd_reg       <= '0;
            seq_vld_reg  <= '0;
            fwd_vld_reg  <= 1'b0;
        end else if (exec_fire) begin
            busy_reg  <= busy_next;
            hseq_reg  <= hseq_next;
            hdest_reg <= hdest_next;
            tc_reg    <= tc_next;
            cd_reg    <= cd_next;
            if (ram_we) begin
                seq_vld_reg[p_addr_reg] <= 1'b1;
                fwd_vld_reg             <= 1'b1;
            end
        end
    end

    // last counter write, forwarded past the memory read
    always_ff @(posedge aclk) begin
        if (ram_we) begin
            fwd_addr_reg <= p_addr_reg;
            fwd_data_reg <= ram_wdata;
        end
    end

    // output register control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_vld_reg <= 1'b0;
        end else if (advance) begin
            o_vld_reg <= p_vld_reg;
        end
    end

    // output register payload
    always_ff @(posedge aclk) begin
        if (exec_fire) begin
            o_ev_reg   <= ev_next;
            o_seq_reg  <= seq_next;
            o_dest_reg <= dest_next;
            o_att_reg  <= att_next;
        end
    end

    assign m_tvalid = o_vld_reg;
    assign m_tuser  = o_ev_reg;
    assign m_tdata  = {3'b000, o_att_reg, o_dest_reg, o_seq_reg};

`ifndef SYNTH
    // a sent packet is held afterwards
    a_sent_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (exec_fire && (ev_next == EV_SENT)) |=> busy_reg)
        else $error("packet not held after send");

    // idle means no timeout state is left over
    a_idle_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> ((tc_reg == '0) && (cd_reg == '0)))
        else $error("timeout state left while idle");

    // counters only advance on an accepted send
    a_ram_write: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (exec_fire && !busy_reg && (p_mode_reg == MODE_SEND)))
        else $error("counter written outside a send");

    // an executed request always lands in the output register
    a_exec_out: assert property (@(posedge aclk) disable iff (!aresetn)
        exec_fire |=> o_vld_reg)
        else $error("executed request lost");
`endif

endmodule
